>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by active-low reset.
`define KRE_ASSERT_NOW(lbl, a_clk, a_rst_n, ante, cons) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
        else $error("kre: same-cycle check failed");

// Next-cycle implication, gated by active-low reset.
`define KRE_ASSERT_NEXT(lbl, a_clk, a_rst_n, ante, cons) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
        else $error("kre: next-cycle check failed");

`endif

>>> hw/rtl/kre_pkg.sv
// Package for the keyboard report to key event block: beat types,
// key status codes and sequencer states. No dependencies.
`timescale 1ns / 1ps

package kre_pkg;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_code_0;
        logic [7:0] key_code_1;
        logic [7:0] key_code_2;
        logic [7:0] key_code_3;
        logic [7:0] key_code_4;
        logic [7:0] key_code_5;
    } kre_report_t;

    typedef struct packed {
        logic       is_release;
        logic [7:0] event_modifiers;
        logic [7:0] event_scancode;
        logic       last_event;
    } kre_event_t;

    localparam logic [1:0] KEY_FREE = 2'd0;
    localparam logic [1:0] KEY_HELD = 2'd1;
    localparam logic [1:0] KEY_JUST = 2'd2;

    localparam logic [7:0] NO_CODE       = 8'd0;
    localparam logic [7:0] OVERFLOW_CODE = 8'd1;
    localparam logic [7:0] FIRST_SCAN    = 8'd2;

    localparam int MAX_SLOTS = 6;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SLOT_RD = 6'b000010,
        ST_SLOT_WR = 6'b000100,
        ST_SCAN_RD = 6'b001000,
        ST_SCAN_WR = 6'b010000,
        ST_FLUSH   = 6'b100000
    } kre_state_t;

endpackage

>>> hw/rtl/kre_stream.sv
// Valid/ready stream interface carrying one payload beat per handshake.
// Payload type is set per instance; no other dependencies.
`timescale 1ns / 1ps

interface kre_stream #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/keyboard_report_to_key_events.sv
// Keyboard boot report to key event converter, top level.
// Events wait in pend until the next one or the end of the walk, so beats trail the walk by
// one event; the final beat leaves from ST_FLUSH with its last flag. Output stalls hold the
// walk. No new report is taken until the walk ends; an overflow report is dropped and the
// block stays ready. Reset (rst_n, async low): per-key valid bits clear at once, so every
// key reads released; no clearing pass is needed. Depends on kre_pkg and kre_stream.
`timescale 1ns / 1ps

module keyboard_report_to_key_events
    import kre_pkg::*;
#(
    parameter int NUM_KEYS     = 100,
    parameter int REPORT_SLOTS = 6
)(
    input  logic      clk,
    input  logic      rst_n,
    kre_stream.sink   report,
    kre_stream.source key_evt
);

    // Index widths follow the table size; the 3-bit slot counter covers up to eight slots.
    localparam int IDX_W  = $clog2(NUM_KEYS);
    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(REPORT_SLOTS - 1);
    localparam logic [IDX_W-1:0]  LAST_KEY  = IDX_W'(NUM_KEYS - 1);
    localparam logic [IDX_W-1:0]  FIRST_KEY = IDX_W'(FIRST_SCAN);
    localparam logic [8:0]        KEY_LIMIT = 9'(NUM_KEYS);

    // Sequencer
    kre_state_t        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0]  key_reg, key_next;

    // Report payload, held for the whole walk
    logic [7:0] mods_reg;
    logic [7:0] codes_reg [0:MAX_SLOTS-1];

    // Key status store: 2-bit status per scancode, valid bit per entry.
    // An entry without its valid bit reads as released.
    logic [1:0]          status_mem [0:NUM_KEYS-1];
    logic [NUM_KEYS-1:0] vld_reg;
    logic [1:0]          rd_data_reg;
    logic                rd_vld_reg;

    // One event waits in pend until the next one shows up or the walk ends;
    // that is how the final beat gets its last flag.
    kre_event_t pend_reg, pend_next;
    logic       pend_vld_reg, pend_vld_next;
    kre_event_t out_reg, out_next;
    logic       out_vld_reg, out_vld_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [1:0]       wr_data;

    logic [7:0]  cur_code;
    logic        code_ok;
    logic [1:0]  cur_status;
    logic        slot_last;
    logic        key_last;
    logic        can_push;
    logic        evt_new;
    logic        evt_rel;
    logic [7:0]  evt_code;
    logic        stall;
    logic        push;
    logic        push_last;

    assign report.ready  = (state_reg == ST_IDLE);
    assign key_evt.valid = out_vld_reg;
    assign key_evt.payload = out_reg;

    assign cur_code   = codes_reg[slot_reg];
    assign code_ok    = (cur_code >= FIRST_SCAN) && ({1'b0, cur_code} < KEY_LIMIT);
    assign cur_status = rd_vld_reg ? rd_data_reg : KEY_FREE;
    assign slot_last  = (slot_reg == LAST_SLOT);
    assign key_last   = (key_reg == LAST_KEY);
    assign can_push   = !out_vld_reg || key_evt.ready;
    // key-down on a released slot code, key-up on a held key in the scan
    assign evt_new    = ((state_reg == ST_SLOT_WR) && (cur_status == KEY_FREE)) ||
                        ((state_reg == ST_SCAN_WR) && (cur_status == KEY_HELD));
    // A new event may only displace pend when the output register frees up.
    assign stall      = evt_new && pend_vld_reg && !can_push;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        key_next   = key_reg;
        rd_en      = 1'b0;
        rd_addr    = key_reg;
        wr_en      = 1'b0;
        wr_addr    = key_reg;
        wr_data    = KEY_FREE;
        evt_rel    = 1'b0;
        evt_code   = cur_code;
        push_last  = 1'b0;
        pend_vld_next = pend_vld_reg;
        pend_next  = pend_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (report.valid && (report.payload.key_code_0 != OVERFLOW_CODE))
                begin
                    state_next = ST_SLOT_RD;
                    slot_next  = '0;
                end
            end
            ST_SLOT_RD:
            begin
                if (cur_code == NO_CODE)
                begin
                    state_next = ST_SCAN_RD;
                end
                else if (!code_ok)
                begin
                    // out-of-table or stray overflow code: skip the slot
                    if (slot_last)
                        state_next = ST_SCAN_RD;
                    else
                        slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cur_code[IDX_W-1:0];
                    state_next = ST_SLOT_WR;
                end
            end
            ST_SLOT_WR:
            begin
                evt_rel  = 1'b0;
                evt_code = cur_code;
                if (!stall)
                begin
                    wr_en   = (cur_status == KEY_FREE) || (cur_status == KEY_HELD);
                    wr_addr = cur_code[IDX_W-1:0];
                    wr_data = KEY_JUST;
                    if (slot_last)
                        state_next = ST_SCAN_RD;
                    else
                    begin
                        state_next = ST_SLOT_RD;
                        slot_next  = slot_reg + 1'b1;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = FIRST_KEY;
                key_next   = FIRST_KEY;
                state_next = ST_SCAN_WR;
            end
            ST_SCAN_WR:
            begin
                // write back key_reg while reading key_reg + 1
                evt_rel  = 1'b1;
                evt_code = 8'(key_reg);
                if (!stall)
                begin
                    wr_en   = (cur_status == KEY_HELD) || (cur_status == KEY_JUST);
                    wr_addr = key_reg;
                    wr_data = (cur_status == KEY_HELD) ? KEY_FREE : KEY_HELD;
                    if (key_last)
                        state_next = ST_FLUSH;
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = key_reg + 1'b1;
                        key_next = key_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                    state_next = ST_IDLE;
                else if (can_push)
                begin
                    push_last     = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // New event replaces pend; the old pend moves out without last.
        if (evt_new && !stall)
        begin
            pend_vld_next             = 1'b1;
            pend_next.is_release      = evt_rel;
            pend_next.event_modifiers = mods_reg;
            pend_next.event_scancode  = evt_code;
            pend_next.last_event      = 1'b0;
        end
    end

    assign push = push_last || (evt_new && !stall && pend_vld_reg);

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (push)
        begin
            out_vld_next        = 1'b1;
            out_next            = pend_reg;
            out_next.last_event = push_last;
        end
        else if (key_evt.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            key_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            key_reg      <= key_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (report.valid && report.ready)
        begin
            mods_reg     <= report.payload.modifier_bits;
            codes_reg[0] <= report.payload.key_code_0;
            codes_reg[1] <= report.payload.key_code_1;
            codes_reg[2] <= report.payload.key_code_2;
            codes_reg[3] <= report.payload.key_code_3;
            codes_reg[4] <= report.payload.key_code_4;
            codes_reg[5] <= report.payload.key_code_5;
        end
    end

    // Key status memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            status_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= status_mem[rd_addr];
    end

endmodule

>>> hw/rtl/kre_checker.sv
// Port-level checker for keyboard_report_to_key_events, bound to the top level.
// Depends on kre_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kre_checker
    import kre_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_code0,
    input logic       out_valid,
    input logic       out_ready,
    input kre_event_t out_payload
);

    // overflow report is dropped and the block is ready again in the next cycle
    `KRE_ASSERT_NEXT(a_overflow_idle, clk, rst_n, in_valid && in_ready && (in_code0 == OVERFLOW_CODE), in_ready)
    // any other report keeps the block busy
    `KRE_ASSERT_NEXT(a_report_busy, clk, rst_n, in_valid && in_ready && (in_code0 != OVERFLOW_CODE), !in_ready)
    // a non-final event means more of this report is still to come
    `KRE_ASSERT_NOW(a_mid_report, clk, rst_n, out_valid && !out_payload.last_event, !in_ready)
    // stalled event beat holds
    `KRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

endmodule

bind keyboard_report_to_key_events kre_checker u_kre_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (report.valid),
    .in_ready    (report.ready),
    .in_code0    (report.payload.key_code_0),
    .out_valid   (key_evt.valid),
    .out_ready   (key_evt.ready),
    .out_payload (key_evt.payload)
);
